@@ hw/rtl/fplf_pkg.sv @@
// Shared types and constants of the four-plane line fit with chi-square cut.
// Used by fplf_axis and four_plane_line_fit_chi2_core; depends on nothing.
`timescale 1ns / 1ps

package fplf_pkg;

  // Register and result widths fixed by the block's interface
  localparam int unsigned GAIN_W      = 24;
  localparam int unsigned LIMIT_W     = 54;
  localparam int unsigned SLOPE_W     = 32;
  localparam int unsigned CHI2_AXIS_W = 53;
  localparam int unsigned CHI2_XY_W   = 54;
  localparam int unsigned CFG_IDX_W   = 2;

  // Fraction bits dropped from the slope product
  localparam int unsigned SLOPE_SHIFT = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SLOPE_GAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHI2_LIMIT = 2'd1;

  // Reset values of the configuration registers
  localparam logic [GAIN_W-1:0]  GAIN_RESET  = 24'd1099512;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 54'h20_0000_0000_0000;

  // Saturation value of a per-axis chi-square
  localparam logic [CHI2_AXIS_W-1:0] CHI2_AXIS_MAX = '1;

  // Load strobes of the four per-axis pipeline stages
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } stage_ld_t;

endpackage

@@ hw/rtl/fplf_axis.sv @@
// Four-stage datapath of one axis: sum, slope numerator, residuals, slope and chi-square.
// Depends on fplf_pkg; stage loads come from the pipeline control in the top level.
`timescale 1ns / 1ps

module fplf_axis #(
  parameter int unsigned COORD_BITS = 20
) (
  input  logic                                 clk_i,
  input  fplf_pkg::stage_ld_t                  ld_i,
  input  logic signed [COORD_BITS-1:0]         h1_i,
  input  logic signed [COORD_BITS-1:0]         h2_i,
  input  logic signed [COORD_BITS-1:0]         h3_i,
  input  logic signed [COORD_BITS-1:0]         h4_i,
  input  logic [fplf_pkg::GAIN_W-1:0]          gain_i,
  output logic signed [COORD_BITS+1:0]         pos_o,
  output logic signed [fplf_pkg::SLOPE_W-1:0]  slope_o,
  output logic [fplf_pkg::CHI2_AXIS_W-1:0]     chi2_o
);

  localparam int unsigned SW   = COORD_BITS + 2;               // hit sum
  localparam int unsigned NW   = COORD_BITS + 4;               // slope numerator
  localparam int unsigned DW   = COORD_BITS + 5;               // residual, signed
  localparam int unsigned AW   = COORD_BITS + 4;               // residual magnitude
  localparam int unsigned QW   = 2 * AW;                       // residual square
  localparam int unsigned SUMW = QW + 2;                       // sum of four squares
  localparam int unsigned SUMX = SUMW + fplf_pkg::CHI2_AXIS_W; // room for compare
  localparam int unsigned PW   = NW + fplf_pkg::GAIN_W + 1;    // slope product
  localparam int unsigned SHW  = PW - fplf_pkg::SLOPE_SHIFT;   // shifted product
  localparam int unsigned EW   = SHW + fplf_pkg::SLOPE_W + 1;  // room for clamp

  localparam logic signed [EW-1:0] SLOPE_HI = EW'(32'sh7FFF_FFFF);
  localparam logic signed [EW-1:0] SLOPE_LO = EW'(32'sh8000_0000);

  // Stage 1: hit sum and slope numerator N = 3*(h4-h1) + (h3-h2)
  logic signed [SW-1:0]         s1_sum_d, s1_sum_q;
  logic signed [NW-1:0]         s1_num_d, s1_num_q;
  logic signed [NW-1:0]         e1, e2, e3, e4, d41;
  logic signed [COORD_BITS-1:0] s1_h_q [4];

  assign e1  = NW'(h1_i);
  assign e2  = NW'(h2_i);
  assign e3  = NW'(h3_i);
  assign e4  = NW'(h4_i);
  assign d41 = e4 - e1;

  assign s1_sum_d = SW'(h1_i) + SW'(h2_i) + SW'(h3_i) + SW'(h4_i);
  assign s1_num_d = (d41 <<< 1) + d41 + (e3 - e2);

  always_ff @(posedge clk_i) begin
    if (ld_i.s1) begin
      s1_sum_q  <= s1_sum_d;
      s1_num_q  <= s1_num_d;
      s1_h_q[0] <= h1_i;
      s1_h_q[1] <= h2_i;
      s1_h_q[2] <= h3_i;
      s1_h_q[3] <= h4_i;
    end
  end

  // Stage 2: residuals 5S + kN - 20h as magnitudes, and the slope product
  logic signed [DW-1:0] es, en, n3, s5;
  logic signed [DW-1:0] res_d [4];
  logic [AW-1:0]        s2_abs_d [4];
  logic [AW-1:0]        s2_abs_q [4];
  logic signed [PW-1:0] s2_prod_d, s2_prod_q;
  logic signed [SW-1:0] s2_sum_q;

  assign es = DW'(s1_sum_q);
  assign en = DW'(s1_num_q);
  assign n3 = (en <<< 1) + en;
  assign s5 = (es <<< 2) + es;

  always_comb begin
    logic signed [DW-1:0] eh [4];
    logic signed [DW-1:0] neg;
    for (int k = 0; k < 4; k++) begin
      eh[k] = DW'(s1_h_q[k]);
    end
    res_d[0] = s5 - n3 - (eh[0] <<< 4) - (eh[0] <<< 2);
    res_d[1] = s5 - en - (eh[1] <<< 4) - (eh[1] <<< 2);
    res_d[2] = s5 + en - (eh[2] <<< 4) - (eh[2] <<< 2);
    res_d[3] = s5 + n3 - (eh[3] <<< 4) - (eh[3] <<< 2);
    for (int k = 0; k < 4; k++) begin
      neg         = -res_d[k];
      s2_abs_d[k] = res_d[k][DW-1] ? neg[AW-1:0] : res_d[k][AW-1:0];
    end
  end

  assign s2_prod_d = PW'(s1_num_q) * PW'($signed({1'b0, gain_i}));

  always_ff @(posedge clk_i) begin
    if (ld_i.s2) begin
      s2_abs_q  <= s2_abs_d;
      s2_prod_q <= s2_prod_d;
      s2_sum_q  <= s1_sum_q;
    end
  end

  // Stage 3: square the residuals, floor-shift and clamp the slope
  logic [QW-1:0]                   s3_sq_d [4];
  logic [QW-1:0]                   s3_sq_q [4];
  logic signed [SHW-1:0]           shifted;
  logic signed [EW-1:0]            shx;
  logic signed [fplf_pkg::SLOPE_W-1:0] s3_slope_d, s3_slope_q;
  logic signed [SW-1:0]            s3_sum_q;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      s3_sq_d[k] = QW'(s2_abs_q[k]) * QW'(s2_abs_q[k]);
    end
  end

  assign shifted = SHW'(s2_prod_q >>> fplf_pkg::SLOPE_SHIFT);
  assign shx     = EW'(shifted);

  always_comb begin
    if (shx > SLOPE_HI) begin
      s3_slope_d = SLOPE_HI[fplf_pkg::SLOPE_W-1:0];
    end else if (shx < SLOPE_LO) begin
      s3_slope_d = SLOPE_LO[fplf_pkg::SLOPE_W-1:0];
    end else begin
      s3_slope_d = shx[fplf_pkg::SLOPE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.s3) begin
      s3_sq_q    <= s3_sq_d;
      s3_slope_q <= s3_slope_d;
      s3_sum_q   <= s2_sum_q;
    end
  end

  // Stage 4: add the squares and saturate the chi-square
  logic [SUMW-1:0]                  sq_sum;
  logic [SUMX-1:0]                  sq_sumx;
  logic [fplf_pkg::CHI2_AXIS_W-1:0] s4_chi2_d, s4_chi2_q;
  logic signed [SW-1:0]             s4_sum_q;
  logic signed [fplf_pkg::SLOPE_W-1:0] s4_slope_q;

  assign sq_sum  = SUMW'(s3_sq_q[0]) + SUMW'(s3_sq_q[1])
                 + SUMW'(s3_sq_q[2]) + SUMW'(s3_sq_q[3]);
  assign sq_sumx = SUMX'(sq_sum);

  assign s4_chi2_d = (sq_sumx > SUMX'(fplf_pkg::CHI2_AXIS_MAX))
                   ? fplf_pkg::CHI2_AXIS_MAX
                   : sq_sumx[fplf_pkg::CHI2_AXIS_W-1:0];

  always_ff @(posedge clk_i) begin
    if (ld_i.s4) begin
      s4_chi2_q  <= s4_chi2_d;
      s4_slope_q <= s3_slope_q;
      s4_sum_q   <= s3_sum_q;
    end
  end

  assign pos_o   = s4_sum_q;
  assign slope_o = s4_slope_q;
  assign chi2_o  = s4_chi2_q;

endmodule

@@ hw/rtl/four_plane_line_fit_chi2_core.sv @@
// Top level of the four-plane straight-line track fit with xy chi-square cut.
// Depends on fplf_pkg and instantiates fplf_axis once for x and once for y.
`timescale 1ns / 1ps

// Usage
//   Input channel: one track candidate per beat, x and y hits on four planes,
//   moved when in_valid_i is high and in_stall_o is low.
//   Output channel: one fit result per candidate, moved when out_valid_o is
//   high and out_stall_i is low. Results leave in input order.
//   Configuration: cfg_we_i writes cfg_data_i into register cfg_index_i
//   (0 slope gain, 1 chi-square limit); other indexes are dropped. Write only
//   while no candidate is in flight.
//   Throughput: one candidate per cycle while out_stall_i is low, set by the
//   five-stage pipeline (sum, residual and slope product, squares, chi-square,
//   accept compare); a result is valid once it reaches the last stage.
//   Stall: each stage holds while the stage after it is full and stalled, so
//   the pipeline fills up to five results, then in_stall_o rises; nothing is
//   dropped or repeated.
//   Reset: the pipeline empties and the registers take their default values
//   (slope gain 1099512, chi-square limit 2^53).
module four_plane_line_fit_chi2_core #(
  parameter int unsigned COORD_BITS = 20
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration write port
  input  logic                                  cfg_we_i,
  input  logic [fplf_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [fplf_pkg::LIMIT_W-1:0]          cfg_data_i,
  // input channel
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [COORD_BITS-1:0]          x_plane1_i,
  input  logic signed [COORD_BITS-1:0]          x_plane2_i,
  input  logic signed [COORD_BITS-1:0]          x_plane3_i,
  input  logic signed [COORD_BITS-1:0]          x_plane4_i,
  input  logic signed [COORD_BITS-1:0]          y_plane1_i,
  input  logic signed [COORD_BITS-1:0]          y_plane2_i,
  input  logic signed [COORD_BITS-1:0]          y_plane3_i,
  input  logic signed [COORD_BITS-1:0]          y_plane4_i,
  // output channel
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [COORD_BITS+1:0]          pos_x_quarter_o,
  output logic signed [fplf_pkg::SLOPE_W-1:0]   slope_x_q24_o,
  output logic [fplf_pkg::CHI2_AXIS_W-1:0]      chi2_x_scaled_o,
  output logic signed [COORD_BITS+1:0]          pos_y_quarter_o,
  output logic signed [fplf_pkg::SLOPE_W-1:0]   slope_y_q24_o,
  output logic [fplf_pkg::CHI2_AXIS_W-1:0]      chi2_y_scaled_o,
  output logic [fplf_pkg::CHI2_XY_W-1:0]        chi2_xy_scaled_o,
  output logic                                  accepted_o
);

  // Configuration registers
  logic [fplf_pkg::GAIN_W-1:0]  gain_q;
  logic [fplf_pkg::LIMIT_W-1:0] limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q  <= fplf_pkg::GAIN_RESET;
      limit_q <= fplf_pkg::LIMIT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        fplf_pkg::CFG_SLOPE_GAIN: gain_q  <= cfg_data_i[fplf_pkg::GAIN_W-1:0];
        fplf_pkg::CFG_CHI2_LIMIT: limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline control: a stage loads when it is empty or its successor moves on
  logic [4:0]          valid_q;
  logic [4:0]          ready;
  logic [4:0]          up_valid;
  fplf_pkg::stage_ld_t ld;
  logic                ld5;

  assign ready[4]    = !valid_q[4] || !out_stall_i;
  assign ready[3]    = !valid_q[3] || ready[4];
  assign ready[2]    = !valid_q[2] || ready[3];
  assign ready[1]    = !valid_q[1] || ready[2];
  assign ready[0]    = !valid_q[0] || ready[1];
  assign up_valid    = {valid_q[3:0], in_valid_i};

  assign ld.s1 = ready[0] && up_valid[0];
  assign ld.s2 = ready[1] && up_valid[1];
  assign ld.s3 = ready[2] && up_valid[2];
  assign ld.s4 = ready[3] && up_valid[3];
  assign ld5   = ready[4] && up_valid[4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < 5; k++) begin
        if (ready[k]) valid_q[k] <= up_valid[k];
      end
    end
  end

  assign in_stall_o  = !ready[0];
  assign out_valid_o = valid_q[4];

  // Per-axis datapaths, stages one to four
  logic signed [COORD_BITS+1:0]        pos_x, pos_y;
  logic signed [fplf_pkg::SLOPE_W-1:0] slope_x, slope_y;
  logic [fplf_pkg::CHI2_AXIS_W-1:0]    chi2_x, chi2_y;

  fplf_axis #(
    .COORD_BITS (COORD_BITS)
  ) u_axis_x (
    .clk_i   (clk_i),
    .ld_i    (ld),
    .h1_i    (x_plane1_i),
    .h2_i    (x_plane2_i),
    .h3_i    (x_plane3_i),
    .h4_i    (x_plane4_i),
    .gain_i  (gain_q),
    .pos_o   (pos_x),
    .slope_o (slope_x),
    .chi2_o  (chi2_x)
  );

  fplf_axis #(
    .COORD_BITS (COORD_BITS)
  ) u_axis_y (
    .clk_i   (clk_i),
    .ld_i    (ld),
    .h1_i    (y_plane1_i),
    .h2_i    (y_plane2_i),
    .h3_i    (y_plane3_i),
    .h4_i    (y_plane4_i),
    .gain_i  (gain_q),
    .pos_o   (pos_y),
    .slope_o (slope_y),
    .chi2_o  (chi2_y)
  );

  // Stage 5: combine the chi-squares and apply the cut; both axis values
  // stay below 2^53, so the sum never reaches the 54-bit limit
  logic [fplf_pkg::CHI2_XY_W-1:0]       xy_d, xy_q;
  logic                                 acc_q;
  logic signed [COORD_BITS+1:0]         pos_x_q, pos_y_q;
  logic signed [fplf_pkg::SLOPE_W-1:0]  slope_x_q, slope_y_q;
  logic [fplf_pkg::CHI2_AXIS_W-1:0]     chi2_x_q, chi2_y_q;

  assign xy_d = fplf_pkg::CHI2_XY_W'(chi2_x) + fplf_pkg::CHI2_XY_W'(chi2_y);

  always_ff @(posedge clk_i) begin
    if (ld5) begin
      xy_q      <= xy_d;
      acc_q     <= (xy_d <= limit_q);
      pos_x_q   <= pos_x;
      pos_y_q   <= pos_y;
      slope_x_q <= slope_x;
      slope_y_q <= slope_y;
      chi2_x_q  <= chi2_x;
      chi2_y_q  <= chi2_y;
    end
  end

  assign pos_x_quarter_o  = pos_x_q;
  assign slope_x_q24_o    = slope_x_q;
  assign chi2_x_scaled_o  = chi2_x_q;
  assign pos_y_quarter_o  = pos_y_q;
  assign slope_y_q24_o    = slope_y_q;
  assign chi2_y_scaled_o  = chi2_y_q;
  assign chi2_xy_scaled_o = xy_q;
  assign accepted_o       = acc_q;

endmodule
